// ----- design/sktlb_pkg.sv -----
// Shared types and constants for the sorted key table lower-bound search.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package sktlb_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int POS_BITS    = IDX_BITS + 1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_CMP_FIRST,
        ST_CMP
    } sktlb_state_t;

    typedef enum logic [2:0] {
        ADDR_WRITE,
        ADDR_HI,
        ADDR_ZERO,
        ADDR_MID_FIRST,
        ADDR_MID_NEXT
    } sktlb_addr_sel_t;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_LEN,
        POS_LO
    } sktlb_pos_sel_t;

    typedef struct packed {
        logic            load;
        logic            ram_wr;
        sktlb_addr_sel_t addr_sel;
        logic            init_lo;
        logic            step;
        logic            finish;
        sktlb_pos_sel_t  pos_sel;
    } sktlb_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic hi_zero;
        logic key_gt;
        logic key_lt;
        logic cont;
    } sktlb_status_t;

endpackage

`default_nettype wire

// ----- design/sorted_key_table_lower_bound_top.sv -----
// Lower-bound search over a sorted key table: a write beat stores a key, a search beat
// returns the first position whose key is not less than the searched key.
// A write never raises busy; neither does a search on an empty table, which raises done
// in the next cycle. Other searches hold busy through the end checks and, where these do
// not settle the result, the bisection; done rises in the same cycle that busy drops, and
// the receiver cannot stall. Reset clears length and control; the table stays undefined.
`default_nettype none

module sorted_key_table_lower_bound_top
    import sktlb_pkg::*;
#(
    parameter int KEY_BITS    = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                req_type,
    input  wire logic [IDX_BITS-1:0] entry_index,
    input  wire logic [KEY_BITS-1:0] key,
    input  wire logic                cfg_we,
    input  wire logic [POS_BITS-1:0] cfg_wdata,
    output logic                     done,
    output logic [POS_BITS-1:0]      position
);

    sktlb_cmd_t    cmd;
    sktlb_status_t status;

    sktlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    sktlb_datapath #(
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_index (entry_index),
        .key         (key),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .status      (status),
        .done        (done),
        .position    (position)
    );

endmodule

`default_nettype wire

// ----- design/sktlb_ram.sv -----
// Generic single-port RAM with a registered read port.
// No dependencies; contents are undefined until written.
`default_nettype none

module sktlb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/sktlb_datapath.sv -----
// Datapath of the lower-bound search: key table RAM, length register, bounds and result.
// Depends on sktlb_pkg and sktlb_ram; steered by sktlb_ctrl through command and status.
`default_nettype none

module sktlb_datapath
    import sktlb_pkg::*;
#(
    parameter int KEY_BITS    = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [IDX_BITS-1:0] entry_index,
    input  wire logic [KEY_BITS-1:0] key,
    input  wire logic                cfg_we,
    input  wire logic [POS_BITS-1:0] cfg_wdata,
    input  wire sktlb_cmd_t          cmd,
    output sktlb_status_t            status,
    output logic                     done,
    output logic [POS_BITS-1:0]      position
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [POS_BITS-1:0] len_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [POS_BITS-1:0] lo_reg;
    logic [POS_BITS-1:0] hi_reg;
    logic [POS_BITS-1:0] mid_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic                done_reg;

    logic [POS_BITS-1:0] lo_next;
    logic [POS_BITS-1:0] hi_next;
    logic [POS_BITS-1:0] mid_next;
    logic [POS_BITS-1:0] pos_next;
    logic [POS_BITS-1:0] len_next;

    logic [AW-1:0]       ram_addr;
    logic                ram_we;
    logic [KEY_BITS-1:0] rd_data;
    logic                key_gt;

    sktlb_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (key),
        .rdata (rd_data)
    );

    // Writes beyond the table are dropped.
    assign ram_we = cmd.ram_wr && (32'(entry_index) < TABLE_DEPTH);

    assign key_gt   = key_reg > rd_data;
    assign lo_next  = key_gt ? mid_reg + POS_BITS'(1) : lo_reg;
    assign hi_next  = key_gt ? hi_reg : mid_reg;
    assign mid_next = lo_next + ((hi_next - lo_next) >> 1);

    assign status.len_zero = (len_reg == '0);
    assign status.hi_zero  = (hi_reg == '0);
    assign status.key_gt   = key_gt;
    assign status.key_lt   = key_reg < rd_data;
    assign status.cont     = lo_next < hi_next;

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_WRITE:     ram_addr = AW'(entry_index);
            ADDR_HI:        ram_addr = AW'(hi_reg);
            ADDR_ZERO:      ram_addr = '0;
            ADDR_MID_FIRST: ram_addr = AW'(hi_reg >> 1);
            ADDR_MID_NEXT:  ram_addr = AW'(mid_next);
            default:        ram_addr = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.pos_sel)
            POS_ZERO: pos_next = '0;
            POS_LEN:  pos_next = len_reg;
            POS_LO:   pos_next = lo_next;
            default:  pos_next = '0;
        endcase
    end

    // A length above the table depth saturates to the depth.
    assign len_next = (32'(cfg_wdata) > TABLE_DEPTH) ? POS_BITS'(TABLE_DEPTH) : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= len_next;
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key;
            hi_reg  <= len_reg - POS_BITS'(1);
        end
        if (cmd.init_lo)
        begin
            lo_reg  <= '0;
            mid_reg <= hi_reg >> 1;
        end
        if (cmd.step)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (cmd.finish)
        begin
            pos_reg <= pos_next;
        end
    end

    assign done     = done_reg;
    assign position = pos_reg;

    // Bisection never lets the lower bound pass the upper bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    // Every result strobe follows a finish command.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.finish))
        else $error("result strobe without finish");

endmodule

`default_nettype wire

// ----- design/sktlb_ctrl.sv -----
// Controller state machine of the lower-bound search: end checks, then bisection.
// Depends on sktlb_pkg; drives sktlb_datapath through command and status.
`default_nettype none

module sktlb_ctrl
    import sktlb_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          req_type,
    input  wire sktlb_status_t status,
    output sktlb_cmd_t         cmd,
    output logic               busy
);

    sktlb_state_t state_reg;
    sktlb_state_t state_next;
    logic         accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_SEARCH) && !status.len_zero)
                begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST:
            begin
                state_next = ST_RD_FIRST;
            end
            ST_RD_FIRST:
            begin
                state_next = status.key_gt ? ST_IDLE : ST_CMP_FIRST;
            end
            ST_CMP_FIRST:
            begin
                state_next = (status.key_lt || status.hi_zero) ? ST_IDLE : ST_CMP;
            end
            ST_CMP:
            begin
                state_next = status.cont ? ST_CMP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '{load: 1'b0, ram_wr: 1'b0, addr_sel: ADDR_WRITE, init_lo: 1'b0,
                step: 1'b0, finish: 1'b0, pos_sel: POS_ZERO};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_WRITE))
                begin
                    cmd.ram_wr = 1'b1;
                end
                else if (accept)
                begin
                    // An empty table answers at once.
                    cmd.load   = !status.len_zero;
                    cmd.finish = status.len_zero;
                end
            end
            ST_RD_LAST:
            begin
                cmd.addr_sel = ADDR_HI;
            end
            ST_RD_FIRST:
            begin
                cmd.addr_sel = ADDR_ZERO;
                cmd.finish   = status.key_gt;
                cmd.pos_sel  = POS_LEN;
            end
            ST_CMP_FIRST:
            begin
                cmd.addr_sel = ADDR_MID_FIRST;
                if (status.key_lt || status.hi_zero)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.init_lo = 1'b1;
                end
            end
            ST_CMP:
            begin
                cmd.addr_sel = ADDR_MID_NEXT;
                cmd.step     = 1'b1;
                cmd.finish   = !status.cont;
                cmd.pos_sel  = POS_LO;
            end
            default:
            begin
                cmd.finish = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // A search on a non-empty table keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_SEARCH) && !status.len_zero) |=> busy)
        else $error("search accepted but block not busy");

    // Finishing a search always returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("busy after finish");

endmodule

`default_nettype wire
